/* sv/tcf_pkg.sv */
package tcf_pkg;

    localparam int CAL_SAMPLES_DEF  = 100;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_W           = 23;
    localparam int CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP   = 1'b1;
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CAL    = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] angle_out;
        logic               cal_done;
    } out_item_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ATAN_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [ATAN_W-1:0] r;
        begin
            case (i)
                5'd0: r = 23'sd2949120;
                5'd1: r = 23'sd1740967;
                5'd2: r = 23'sd919879;
                5'd3: r = 23'sd466945;
                5'd4: r = 23'sd234379;
                5'd5: r = 23'sd117304;
                5'd6: r = 23'sd58666;
                5'd7: r = 23'sd29335;
                5'd8: r = 23'sd14668;
                5'd9: r = 23'sd7334;
                5'd10: r = 23'sd3667;
                5'd11: r = 23'sd1833;
                5'd12: r = 23'sd917;
                5'd13: r = 23'sd458;
                5'd14: r = 23'sd229;
                5'd15: r = 23'sd115;
                5'd16: r = 23'sd57;
                5'd17: r = 23'sd29;
                5'd18: r = 23'sd14;
                5'd19: r = 23'sd7;
                5'd20: r = 23'sd4;
                5'd21: r = 23'sd2;
                5'd22: r = 23'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* sv/tilt_complementary_filter_top.sv */
// an update beat runs prep, the serial cordic iterations, the blend states MUL0-MUL3
//   and the final clamp before out_valid; a calibration beat accumulates and goes to
//   out_valid, the closing sample first runs two reciprocal-multiply divides, x then z;
// in_ready stays low from accept until the result beat leaves, one beat at a time
// reset: angle, offsets, sums and count clear; weight 62915, step 12807
module tilt_complementary_filter_top #(
    parameter int CAL_SAMPLES  = tcf_pkg::CAL_SAMPLES_DEF,
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tcf_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcf_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]                   cfg_data
);

    // count and sum widths follow the sample count
    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W  = 17 + CNT_W;
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
    // rounding divide: dividend 2|s|+n, divisor 2n
    localparam int DIVD_W = SUM_W + 2;
    localparam logic [DIVD_W-1:0] DIV_N  = DIVD_W'(CAL_SAMPLES);
    // reciprocal of 2n, exact for any dividend below 2^DIVD_W
    localparam int DIV_L   = $clog2(2 * CAL_SAMPLES);
    localparam int DIV_K   = DIVD_W + DIV_L;
    localparam int DIVM_W  = DIVD_W + 2;
    localparam int DPROD_W = DIVD_W + DIVM_W;
    localparam logic [DIVM_W-1:0] DIV_M = DIVM_W'(((64'd1 << DIV_K)
        + 64'(2 * CAL_SAMPLES) - 64'd1) / 64'(2 * CAL_SAMPLES));
    // cordic datapath: 17-bit inputs scaled by 2^14 plus gain headroom
    localparam int CW = 34;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_CORD  = 4'd2;
    localparam logic [3:0] S_MUL0  = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_MUL3  = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_CAL   = 4'd8;
    localparam logic [3:0] S_DIVX  = 4'd9;
    localparam logic [3:0] S_DIVZ  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [16:0] weight_reg;
    logic [15:0] step_reg;
    logic signed [23:0] angle_reg;
    logic signed [15:0] off_x_reg;
    logic signed [16:0] off_z_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_z_reg;
    logic [CNT_W-1:0] cnt_reg;
    tcf_pkg::in_item_t item_reg;
    logic done_reg;

    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [31:0]   cz_reg;
    logic [STEP_W-1:0]    it_reg;
    logic                 zero_reg;

    // multiply-accumulate registers of the blend
    logic signed [35:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic signed [24:0] accang_reg;

    // offset divider: operand, then quotient
    logic [DIVD_W-1:0] dq_reg;
    logic [1:0]        dcnt_reg;
    logic              dneg_reg;

    // a config beat takes the idle slot, the input waits behind it
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data.angle_out = angle_reg;
    assign out_data.cal_done  = done_reg;

    // corrected samples
    logic signed [17:0] dx, dz;
    logic signed [16:0] sx, sz;
    always_comb
    begin
        dx = 18'(item_reg.accel_x) - 18'(off_x_reg);
        dz = 18'(item_reg.accel_z) - 18'(off_z_reg);
        sx = (dx > 18'sd32767) ? 17'sd32767 : (dx < -18'sd32768) ? -17'sd32768 : dx[16:0];
        sz = (dz > 18'sd32767) ? 17'sd32767 : (dz < -18'sd32768) ? -17'sd32768 : dz[16:0];
    end

    // shared cordic step
    logic signed [CW-1:0] sh_x, sh_y;
    logic [4:0] it5;
    always_comb
    begin
        it5  = 5'(it_reg);
        sh_x = cy_reg >>> it_reg;
        sh_y = cx_reg >>> it_reg;
    end

    logic [16:0] w_eff;
    assign w_eff = weight_reg[16] ? 17'h10000 : weight_reg;

    // divider operand build
    logic signed [SUM_W-1:0] dsum;
    logic [SUM_W-1:0] dabs;
    assign dsum = (state_reg == S_DIVX) ? sum_x_reg : sum_z_reg;
    assign dabs = dsum[SUM_W-1] ? SUM_W'(-dsum) : SUM_W'(dsum);

    logic [DPROD_W-1:0] dprod;
    assign dprod = DPROD_W'(dq_reg) * DPROD_W'(DIV_M);

    logic signed [66:0] rnd;
    logic signed [34:0] rsh;
    assign rnd = acc_reg + (67'sd1 <<< 31);
    assign rsh = 35'(rnd >>> 32);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            weight_reg <= 17'd62915;
            step_reg   <= 16'd12807;
            angle_reg  <= '0;
            off_x_reg  <= '0;
            off_z_reg  <= '0;
            sum_x_reg  <= '0;
            sum_z_reg  <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            dcnt_reg   <= '0;
            it_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            tcf_pkg::REG_GYRO_WEIGHT: weight_reg <= cfg_data;
                            tcf_pkg::REG_GYRO_STEP:   step_reg   <= cfg_data[15:0];
                            default: ;
                        endcase
                    end
                    else if (in_valid)
                    begin
                        item_reg <= in_data;
                        done_reg <= 1'b0;
                        state_reg <= (in_data.op == tcf_pkg::OP_CAL) ? S_CAL : S_PREP;
                    end
                end
                S_PREP:
                begin
                    // fold negative z into the right half plane
                    zero_reg <= (sx == 17'sd0) && (sz == 17'sd0);
                    if (sz < 0)
                    begin
                        cx_reg <= CW'(-sz) <<< 14;
                        cy_reg <= CW'(-sx) <<< 14;
                        cz_reg <= (sx >= 0) ? 32'sd11796480 : -32'sd11796480;
                    end
                    else
                    begin
                        cx_reg <= CW'(sz) <<< 14;
                        cy_reg <= CW'(sx) <<< 14;
                        cz_reg <= '0;
                    end
                    it_reg    <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (it_reg == STEP_W'(CORDIC_STEPS))
                        state_reg <= S_MUL0;
                    else
                    begin
                        if (cy_reg < 0)
                        begin
                            cx_reg <= cx_reg - sh_x;
                            cy_reg <= cy_reg + sh_y;
                            cz_reg <= cz_reg - 32'(tcf_pkg::atan_lut(it5));
                        end
                        else
                        begin
                            cx_reg <= cx_reg + sh_x;
                            cy_reg <= cy_reg - sh_y;
                            cz_reg <= cz_reg + 32'(tcf_pkg::atan_lut(it5));
                        end
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_MUL0:
                begin
                    accang_reg <= zero_reg ? '0 : 25'((cz_reg + 32'sd128) >>> 8);
                    // gyro term
                    prod_reg   <= 36'($signed(item_reg.gyro_x) * $signed({1'b0, step_reg}));
                    state_reg  <= S_MUL1;
                end
                S_MUL1:
                begin
                    // pred = angle*65536 + gx*step, kept in prod/acc
                    acc_reg   <= 67'(prod_reg) + (67'(angle_reg) <<< 16);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    // w * pred, pred is 41 bits: split in two partial products
                    prod_reg  <= 36'($signed({1'b0, w_eff}) * $signed({1'b0, acc_reg[15:0]}));
                    acc_reg   <= 67'($signed({1'b0, w_eff}) * $signed(acc_reg[40:16])) <<< 16;
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    acc_reg <= acc_reg + 67'(prod_reg)
                        + (67'($signed({1'b0, 17'(17'h10000 - w_eff)}) * accang_reg) <<< 16);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (rsh > 35'sd8388607)
                        angle_reg <= 24'sd8388607;
                    else if (rsh < -35'sd8388608)
                        angle_reg <= -24'sd8388608;
                    else
                        angle_reg <= rsh[23:0];
                    state_reg <= S_OUT;
                end
                S_CAL:
                begin
                    sum_x_reg <= sum_x_reg + SUM_W'(item_reg.accel_x);
                    sum_z_reg <= sum_z_reg + SUM_W'(item_reg.accel_z);
                    if (cnt_reg + 1'b1 >= CNT_W'(CAL_SAMPLES))
                    begin
                        cnt_reg   <= '0;
                        dcnt_reg  <= '0;
                        state_reg <= S_DIVX;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_DIVX, S_DIVZ:
                begin
                    if (dcnt_reg == 2'd0)
                    begin
                        // rounding dividend from the magnitude of the sum
                        dq_reg   <= (DIVD_W'(dabs) <<< 1) + DIV_N;
                        dneg_reg <= dsum[SUM_W-1];
                        dcnt_reg <= 2'd1;
                    end
                    else if (dcnt_reg == 2'd1)
                    begin
                        // quotient by reciprocal multiply
                        dq_reg   <= DIVD_W'(dprod >> DIV_K);
                        dcnt_reg <= 2'd2;
                    end
                    else
                    begin
                        dcnt_reg <= '0;
                        if (state_reg == S_DIVX)
                        begin
                            off_x_reg <= dneg_reg ? 16'(-dq_reg) : 16'(dq_reg);
                            state_reg <= S_DIVZ;
                        end
                        else
                        begin
                            off_z_reg <= (dneg_reg ? 17'(-dq_reg) : 17'(dq_reg)) - 17'sd8192;
                            sum_x_reg <= '0;
                            sum_z_reg <= '0;
                            done_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // no input accepted while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input accepted during output");
    // update beats never flag calibration done
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && item_reg.op == tcf_pkg::OP_UPDATE) |-> !out_data.cal_done)
        else $error("cal_done on update beat");
    // the calibration count stays below the sample count
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg < CNT_W'(CAL_SAMPLES))
        else $error("cal count overflow");
`endif

endmodule

/* dv/tilt_filter_checker.sv */
`timescale 1ns / 100ps

module tilt_filter_checker #(
    parameter int CAL_SAMPLES  = tcf_pkg::CAL_SAMPLES_DEF,
    parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  tcf_pkg::in_item_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  tcf_pkg::out_item_t            out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [tcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [16:0]                   cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import tcf_pkg::*;

    // atan(2^-i) in 1/65536 degree
    localparam longint ARCTAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    longint    weight_q16;
    longint    step_q16;
    longint    angle_q8;
    longint    ofs_x;
    longint    ofs_z;
    longint    acc_x;
    longint    acc_z;
    int        n_taken;
    out_item_t angle_queue[$];

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mean_round(longint s);
        longint a;
        longint q;
        a = s < 0 ? -s : s;
        q = (2 * a + CAL_SAMPLES) / (2 * CAL_SAMPLES);
        return s < 0 ? -q : q;
    endfunction

    function automatic longint accel_tilt(longint y, longint x);
        longint base;
        longint za;
        longint xv;
        longint yv;
        longint dx;
        longint dy;
        base = 0;
        za = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            base = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        xv = x * 16384;
        yv = y * 16384;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = shr_arith(yv, i);
            dy = shr_arith(xv, i);
            if (yv < 0)
            begin
                xv -= dx;
                yv += dy;
                za -= ARCTAN_DEG[i];
            end
            else
            begin
                xv += dx;
                yv -= dy;
                za += ARCTAN_DEG[i];
            end
        end
        return shr_arith(base + za + 128, 8);
    endfunction

    task automatic predict_beat(in_item_t b);
        out_item_t r;
        longint    cx;
        longint    cz;
        longint    w;
        longint    pred;
        longint    blend;
        r.cal_done = 1'b0;
        if (b.op == OP_CAL)
        begin
            acc_x += b.accel_x;
            acc_z += b.accel_z;
            n_taken++;
            if (n_taken >= CAL_SAMPLES)
            begin
                ofs_x = mean_round(acc_x);
                ofs_z = mean_round(acc_z) - 8192;
                acc_x = 0;
                acc_z = 0;
                n_taken = 0;
                r.cal_done = 1'b1;
            end
        end
        else
        begin
            cx = clamp(longint'(b.accel_x) - ofs_x, -32768, 32767);
            cz = clamp(longint'(b.accel_z) - ofs_z, -32768, 32767);
            w = weight_q16 > 65536 ? 65536 : weight_q16;
            pred = angle_q8 * 65536 + longint'(b.gyro_x) * step_q16;
            blend = w * pred + (65536 - w) * accel_tilt(cx, cz) * 65536;
            angle_q8 = clamp(shr_arith(blend + (64'sd1 <<< 31), 32), -8388608, 8388607);
        end
        r.angle_out = angle_q8[23:0];
        angle_queue.push_back(r);
    endtask

    assign pending = angle_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            weight_q16 = 62915;
            step_q16 = 12807;
            angle_q8 = 0;
            ofs_x = 0;
            ofs_z = 0;
            acc_x = 0;
            acc_z = 0;
            n_taken = 0;
            fail_count = 0;
            angle_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GYRO_WEIGHT)
                    weight_q16 = cfg_data;
                else if (cfg_index == REG_GYRO_STEP)
                    step_q16 = cfg_data[15:0];
            end
            if (out_valid && out_ready)
            begin
                if (angle_queue.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    exp_r = angle_queue.pop_front();
                    if (out_data.angle_out !== exp_r.angle_out)
                    begin
                        $error("angle_out expected %0d actual %0d",
                               exp_r.angle_out, out_data.angle_out);
                        fail_count++;
                    end
                    if (out_data.cal_done !== exp_r.cal_done)
                    begin
                        $error("cal_done expected %0d actual %0d",
                               exp_r.cal_done, out_data.cal_done);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                predict_beat(in_data);
        end
    end
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
    import tcf_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [16:0]          cfg_data;
    int                   fail_count;
    int                   pending;
    bit                   stall_sink;

    tilt_complementary_filter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // watches all three channels, predicts and compares
    tilt_filter_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink side: random back-pressure, with quiet stretches
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_sink)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    // one beat; valid held until accepted, dropped only ahead of a gap
    task automatic send_beat(logic op, logic [15:0] ax, logic [15:0] az, logic [15:0] gx);
        in_item_t b;
        int       g;
        b.op = op;
        b.accel_x = ax;
        b.accel_z = az;
        b.gyro_x = gx;
        g = gap_len();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        // an extra wait before the write; cfg_ready holds it off until the block is idle anyway
        repeat (60) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // full calibration run: CAL_SAMPLES_DEF samples around (nx, nz) with uniform noise of up to spread
    task automatic calibrate(int nx, int nz, int spread);
        for (int i = 0; i < CAL_SAMPLES_DEF; i++)
            send_beat(OP_CAL, 16'(nx + $urandom_range(0, 2 * spread) - spread),
                      16'(nz + $urandom_range(0, 2 * spread) - spread), 16'($urandom));
    endtask

    task automatic random_update();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            send_beat(OP_UPDATE, 16'($urandom_range(0, 16000) - 8000),
                      16'($urandom_range(0, 32000) - 16000),
                      16'($urandom_range(0, 4000) - 2000));
        else
            send_beat(OP_UPDATE, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GYRO_WEIGHT;
        cfg_data = '0;
        stall_sink = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero vector, negative z on both sides of x
        send_beat(OP_UPDATE, 16'h0000, 16'h0000, 16'h0000);
        send_beat(OP_UPDATE, 16'h7fff, 16'h7fff, 16'h7fff);
        send_beat(OP_UPDATE, 16'h8000, 16'h8000, 16'h8000);
        send_beat(OP_UPDATE, 16'h1000, 16'hc000, 16'h0100);
        send_beat(OP_UPDATE, 16'hf000, 16'hc000, 16'hff00);
        send_beat(OP_UPDATE, 16'h0000, 16'hc000, 16'h0000);
        send_beat(OP_UPDATE, 16'h7fff, 16'h0000, 16'h8000);
        send_beat(OP_UPDATE, 16'h8000, 16'h0000, 16'h7fff);
        send_beat(OP_UPDATE, 16'h5555, 16'haaaa, 16'h5555);
        send_beat(OP_CAL, 16'haaaa, 16'h5555, 16'haaaa);

        // full weight with max step: the angle follows the gyro term alone, up and then back down
        write_reg(REG_GYRO_WEIGHT, 17'd65536);
        write_reg(REG_GYRO_STEP, 17'h0ffff);
        repeat (6) send_beat(OP_UPDATE, 16'h0000, 16'h2000, 16'h7fff);
        repeat (6) send_beat(OP_UPDATE, 16'h0000, 16'h2000, 16'h8000);
        // oversized weight clamps to unity
        write_reg(REG_GYRO_WEIGHT, 17'h1ffff);
        send_beat(OP_UPDATE, 16'h1234, 16'h2000, 16'h0010);
        write_reg(REG_GYRO_WEIGHT, 17'd0);
        write_reg(REG_GYRO_STEP, 17'd0);
        send_beat(OP_UPDATE, 16'h8000, 16'h7fff, 16'h7fff);

        stall_sink = 1'b1;
        // random phases across weight/step settings, each with a calibration run
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_reg(REG_GYRO_WEIGHT, 17'd62915);
                1: write_reg(REG_GYRO_WEIGHT, 17'd65536);
                2: write_reg(REG_GYRO_WEIGHT, 17'd0);
                default: write_reg(REG_GYRO_WEIGHT, 17'($urandom_range(0, 131071)));
            endcase
            case (ph)
                0: write_reg(REG_GYRO_STEP, 17'd12807);
                1: write_reg(REG_GYRO_STEP, 17'h0ffff);
                2: write_reg(REG_GYRO_STEP, 17'd0);
                default: write_reg(REG_GYRO_STEP, {1'b0, 16'($urandom)});
            endcase
            stall_sink = (ph != 3);
            if (ph == 5)
                calibrate(-32768, 32767, 0);
            else if (ph == 4)
                calibrate(32767, -32768, 0);
            else
                calibrate($urandom_range(0, 4000) - 2000,
                          $urandom_range(0, 20000) - 10000, 300);
            repeat (130) random_update();
            // broken calibration: a few samples then back to updates
            repeat ($urandom_range(1, 5))
                send_beat(OP_CAL, 16'($urandom), 16'($urandom), 16'($urandom));
            repeat (20) random_update();
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // timeout for about 1500 beats, set well above their worst-case run time
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
